// ===== hdl/tdh_pkg.sv =====
package tdh_pkg;

  // Defaults for the top-level parameters.
  localparam int POS_WIDTH_DEF    = 32;
  localparam int INDEX_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_TIME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED_SQ  = 1'd1;
  localparam logic [31:0] INV_STEP_TIME_RESET = 32'd65536;
  localparam logic [31:0] MIN_SPEED_SQ_RESET  = 32'd0;

  // CORDIC datapath widths and constants (angles in Q30 radians).
  localparam int XY_W  = 36;
  localparam int ANG_W = 35;
  localparam logic signed [ANG_W-1:0] PI_Q30   = 35'sd3373259426;
  localparam logic signed [XY_W-1:0]  GAIN_Q30 = 36'sd652032874;
  localparam logic signed [15:0]      ONE_Q14  = 16'sd16384;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic        [15:0] sample_index;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic signed [15:0] heading_w;
    logic signed [15:0] heading_z;
    logic               end_of_run;
    logic               too_short;
  } out_item_t;

  // Request from the sequencer to every lane.
  typedef struct packed {
    logic go;
    logic sq;
    logic central;
  } lane_req_t;

  // What one lane hands back.
  typedef struct packed {
    logic signed [31:0] scaled;
    logic        [63:0] prod;
  } lane_res_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [ANG_W-1:0] r;
    case (i)
      5'd0:    r = 35'sd843314857;
      5'd1:    r = 35'sd497837829;
      5'd2:    r = 35'sd263043837;
      5'd3:    r = 35'sd133525159;
      5'd4:    r = 35'sd67021687;
      5'd5:    r = 35'sd33543516;
      5'd6:    r = 35'sd16775851;
      5'd7:    r = 35'sd8388437;
      5'd8:    r = 35'sd4194283;
      5'd9:    r = 35'sd2097149;
      5'd10:   r = 35'sd1048576;
      5'd11:   r = 35'sd524288;
      5'd12:   r = 35'sd262144;
      5'd13:   r = 35'sd131072;
      5'd14:   r = 35'sd65536;
      5'd15:   r = 35'sd32768;
      5'd16:   r = 35'sd16384;
      5'd17:   r = 35'sd8192;
      5'd18:   r = 35'sd4096;
      5'd19:   r = 35'sd2048;
      5'd20:   r = 35'sd1024;
      5'd21:   r = 35'sd512;
      5'd22:   r = 35'sd256;
      5'd23:   r = 35'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round a Q30 value to Q1.14 and clamp to plus or minus one.
  function automatic logic signed [15:0] to_q14(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] r;
    r = (v + 36'sd32768) >>> 16;
    if (r > 36'sd16384) begin
      r = 36'sd16384;
    end else if (r < -36'sd16384) begin
      r = -36'sd16384;
    end
    return r[15:0];
  endfunction

endpackage

// ===== hdl/trajectory_differentiator_heading.sv =====
// Trajectory differentiator with heading.
// Input channel in_valid/in_ready/in_data carries one 3D position beat per
// sample; last_sample closes the sequence. Output channel
// out_valid/out_ready/out_data carries velocity, acceleration and a yaw
// quaternion for one sample per beat. cfg_we/cfg_index/cfg_data write
// inv_step_time (index 0) and min_speed_sq (index 1). The user must write them
// only while the block is idle; the block itself does not enforce this.
// Result i leaves after sample i+2 is taken; the last sample flushes up to
// three results. A one-sample sequence gives a single too_short beat.
// An item is handled in steps: take the sample and form its velocity (and
// the last velocity on a last sample), then per result the acceleration,
// the squared speed, the hold decision, the CORDIC when the heading is
// updated, and the output. The three axis lanes each own one multiplier
// pair, reused for every step, and the CORDIC is iterative.
// Reset clears the sample count, the held heading (to identity) and the
// output valid flag, and restores the register defaults. When the receiver
// stalls, a finished result waits in the output register; the block takes
// the next input sample meanwhile and stops only when it has a further
// result to place.
module trajectory_differentiator_heading #(
  parameter int POS_WIDTH    = tdh_pkg::POS_WIDTH_DEF,
  parameter int INDEX_WIDTH  = tdh_pkg::INDEX_WIDTH_DEF,
  parameter int CORDIC_STEPS = tdh_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tdh_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tdh_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [tdh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import tdh_pkg::*;

  localparam int PW  = (POS_WIDTH > 32) ? 32 : POS_WIDTH;
  localparam int PSH = 32 - PW;
  localparam int IW  = INDEX_WIDTH;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_VN    = 12'b000000000010,
    S_VN_W  = 12'b000000000100,
    S_VL    = 12'b000000001000,
    S_VL_W  = 12'b000000010000,
    S_ACC   = 12'b000000100000,
    S_ACC_W = 12'b000001000000,
    S_SQ    = 12'b000010000000,
    S_SQ_W  = 12'b000100000000,
    S_SUM   = 12'b001000000000,
    S_ROT   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t             state;
  logic [IW-1:0]      seen;
  logic [1:0]         e;
  logic               last_r;
  logic               short_r;
  logic [31:0]        inv_step_time;
  logic [31:0]        min_speed_sq;
  logic signed [31:0] pcur [3];
  logic signed [31:0] p1   [3];
  logic signed [31:0] p2   [3];
  logic signed [31:0] v1   [3];
  logic signed [31:0] v2   [3];
  logic signed [31:0] vn   [3];
  logic signed [31:0] vl   [3];
  logic signed [31:0] accr [3];
  logic signed [31:0] ev   [3];
  logic        [63:0] sqp  [3];
  logic signed [31:0] lane_a [3];
  logic signed [31:0] lane_b [3];
  lane_res_t          lane_res [3];
  lane_req_t          req;
  logic signed [15:0] hw;
  logic signed [15:0] hz;
  logic [15:0]        res_idx;
  logic [IW:0]        idx_raw;
  logic [65:0]        speed_sq;
  logic               held;
  logic               out_free;
  logic               emit_done;
  logic               finish;
  logic               seen_one;
  logic               seen_two;
  logic               seen_many;
  logic               cordic_start;
  logic               cordic_done;
  logic signed [15:0] cordic_w;
  logic signed [15:0] cordic_z;

  // Sign extension of a position from its configured width.
  function automatic logic signed [31:0] sx(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v <<< PSH;
    return t >>> PSH;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_step_time <= INV_STEP_TIME_RESET;
      min_speed_sq  <= MIN_SPEED_SQ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_STEP_TIME: inv_step_time <= cfg_data;
        REG_MIN_SPEED_SQ:  min_speed_sq  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign seen_one  = (seen == IW'(1));
  assign seen_two  = (seen == IW'(2));
  assign seen_many = (seen > IW'(1));
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Velocity of the result in hand.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      case (e)
        2'd0:    ev[j] = v1[j];
        2'd1:    ev[j] = vn[j];
        default: ev[j] = vl[j];
      endcase
    end
  end

  // Operands and request for the three lanes.
  always_comb begin
    req = '0;
    for (int j = 0; j < 3; j++) begin
      lane_a[j] = '0;
      lane_b[j] = '0;
    end
    case (state)
      S_VN: begin
        req.go      = 1'b1;
        req.central = !seen_one;
        for (int j = 0; j < 3; j++) begin
          lane_a[j] = pcur[j];
          lane_b[j] = seen_one ? p1[j] : p2[j];
        end
      end
      S_VL: begin
        req.go = 1'b1;
        for (int j = 0; j < 3; j++) begin
          lane_a[j] = pcur[j];
          lane_b[j] = p1[j];
        end
      end
      S_ACC: begin
        req.go = 1'b1;
        case (e)
          2'd0:    req.central = !seen_two;
          2'd1:    req.central = !seen_one;
          default: req.central = 1'b0;
        endcase
        for (int j = 0; j < 3; j++) begin
          case (e)
            2'd0: begin
              lane_a[j] = vn[j];
              lane_b[j] = seen_two ? v1[j] : v2[j];
            end
            2'd1: begin
              lane_a[j] = vl[j];
              lane_b[j] = seen_one ? vn[j] : v1[j];
            end
            default: begin
              lane_a[j] = vl[j];
              lane_b[j] = vn[j];
            end
          endcase
        end
      end
      S_SQ: begin
        req.go = 1'b1;
        req.sq = 1'b1;
        for (int j = 0; j < 3; j++) begin
          lane_a[j] = ev[j];
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    tdh_lane u_lane (
      .clk           (clk),
      .req           (req),
      .a             (lane_a[g]),
      .b             (lane_b[g]),
      .inv_step_time (inv_step_time),
      .res           (lane_res[g])
    );
  end

  // Merge of the lanes: squared speed and the hold decision.
  always_comb begin
    speed_sq = 66'(sqp[0]) + 66'(sqp[1]) + 66'(sqp[2]);
    held     = (ev[0] == 0 && ev[1] == 0 && ev[2] == 0) ||
               (speed_sq[65:16] < 50'(min_speed_sq));
    idx_raw  = {1'b0, seen} + (IW + 1)'(e) - (IW + 1)'(2);
    res_idx  = (32'(idx_raw[IW-1:0]) > 32'h0000FFFF) ? 16'hFFFF : 16'(idx_raw[IW-1:0]);
  end

  assign cordic_start = (state == S_SUM) && !held;

  tdh_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .vx    (ev[0]),
    .vy    (ev[1]),
    .done  (cordic_done),
    .w     (cordic_w),
    .z     (cordic_z)
  );

  // End of an item's work: the last result placed, or no result at all.
  always_comb begin
    emit_done = short_r || (e == 2'd2) || (e == 2'd0 && !last_r);
    finish    = ((state == S_OUT) && out_free && emit_done) ||
                ((state == S_VN_W) && !last_r && seen_one);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seen  <= '0;
      e     <= '0;
      hw    <= ONE_Q14;
      hz    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_r  <= in_data.last_sample;
            pcur[0] <= sx(in_data.pos_x);
            pcur[1] <= sx(in_data.pos_y);
            pcur[2] <= sx(in_data.pos_z);
            short_r <= 1'b0;
            if (seen == '0) begin
              if (in_data.last_sample) begin
                short_r <= 1'b1;
                state   <= S_OUT;
              end else begin
                p1[0] <= sx(in_data.pos_x);
                p1[1] <= sx(in_data.pos_y);
                p1[2] <= sx(in_data.pos_z);
                seen  <= IW'(1);
              end
            end else begin
              state <= S_VN;
            end
          end
        end
        S_VN:   state <= S_VN_W;
        S_VN_W: begin
          for (int j = 0; j < 3; j++) begin
            vn[j] <= lane_res[j].scaled;
          end
          if (last_r) begin
            state <= S_VL;
          end else if (seen_many) begin
            e     <= 2'd0;
            state <= S_ACC;
          end
        end
        S_VL:   state <= S_VL_W;
        S_VL_W: begin
          for (int j = 0; j < 3; j++) begin
            vl[j] <= lane_res[j].scaled;
          end
          e     <= seen_many ? 2'd0 : 2'd1;
          state <= S_ACC;
        end
        S_ACC:   state <= S_ACC_W;
        S_ACC_W: begin
          for (int j = 0; j < 3; j++) begin
            accr[j] <= lane_res[j].scaled;
          end
          state <= S_SQ;
        end
        S_SQ:   state <= S_SQ_W;
        S_SQ_W: begin
          for (int j = 0; j < 3; j++) begin
            sqp[j] <= lane_res[j].prod;
          end
          state <= S_SUM;
        end
        S_SUM:  state <= held ? S_OUT : S_ROT;
        S_ROT: begin
          if (cordic_done) begin
            hw    <= cordic_w;
            hz    <= cordic_z;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free && !emit_done) begin
            e     <= e + 2'd1;
            state <= S_ACC;
          end
        end
        default: state <= S_IDLE;
      endcase

      // History update or restart once the item is complete. On the second
      // sample the new velocity comes straight from the lanes.
      if (finish) begin
        state <= S_IDLE;
        if (last_r) begin
          seen <= '0;
          hw   <= ONE_Q14;
          hz   <= '0;
        end else begin
          for (int j = 0; j < 3; j++) begin
            p2[j] <= p1[j];
            p1[j] <= pcur[j];
            v2[j] <= v1[j];
            v1[j] <= (state == S_VN_W) ? lane_res[j].scaled : vn[j];
          end
          if (!(&seen)) begin
            seen <= seen + 1'b1;
          end
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
      if (short_r) begin
        out_data.sample_index <= '0;
        out_data.vel_x        <= '0;
        out_data.vel_y        <= '0;
        out_data.vel_z        <= '0;
        out_data.acc_x        <= '0;
        out_data.acc_y        <= '0;
        out_data.acc_z        <= '0;
        out_data.heading_w    <= '0;
        out_data.heading_z    <= '0;
        out_data.end_of_run   <= 1'b0;
        out_data.too_short    <= 1'b1;
      end else begin
        out_data.sample_index <= res_idx;
        out_data.vel_x        <= ev[0];
        out_data.vel_y        <= ev[1];
        out_data.vel_z        <= ev[2];
        out_data.acc_x        <= accr[0];
        out_data.acc_y        <= accr[1];
        out_data.acc_z        <= accr[2];
        out_data.heading_w    <= hw;
        out_data.heading_z    <= hz;
        out_data.end_of_run   <= (e == 2'd2);
        out_data.too_short    <= 1'b0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // A too-short beat carries nothing else.
  a_short_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.too_short |->
      !out_data.end_of_run && out_data.vel_x == 0 && out_data.heading_w == 0)
    else $error("too_short beat carries data");

  // The CORDIC finishes only while the sequencer waits for it.
  a_cordic_wait: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> state == S_ROT)
    else $error("CORDIC result with no one waiting");

  // A placed heading lies within plus or minus one.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.heading_w <= ONE_Q14 && out_data.heading_w >= -ONE_Q14)
    else $error("heading out of range");

  // No input is taken while a result is being built.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> !in_ready)
    else $error("input taken during result placement");

endmodule

// ===== hdl/tdh_lane.sv =====
module tdh_lane (
  input  logic                      clk,
  input  tdh_pkg::lane_req_t        req,
  input  logic signed [31:0]        a,
  input  logic signed [31:0]        b,
  input  logic        [31:0]        inv_step_time,
  output tdh_pkg::lane_res_t        res
);
  import tdh_pkg::*;

  logic signed [32:0] d;
  logic        [32:0] mag;
  logic        [31:0] m;
  logic        [48:0] ph;
  logic        [48:0] pl;
  logic               neg;
  logic               central;
  logic        [49:0] t;

  // Difference and its magnitude; a square multiplies the magnitude by itself.
  always_comb begin
    d   = {a[31], a} - {b[31], b};
    mag = d[32] ? 33'(-d) : 33'(d);
    m   = req.sq ? mag[31:0] : inv_step_time;
  end

  // Two partial products, registered.
  always_ff @(posedge clk) begin
    if (req.go) begin
      ph      <= mag * m[31:16];
      pl      <= mag * m[15:0];
      neg     <= d[32];
      central <= req.central;
    end
  end

  // Rounding, halving for a central difference and saturation.
  always_comb begin
    t = {1'b0, ph} + ((50'(pl) + (central ? 50'h10000 : 50'h8000)) >> 16);
    if (central) begin
      t = t >> 1;
    end
    if (neg) begin
      res.scaled = (t > 50'h80000000) ? 32'sh80000000 : -$signed(t[31:0]);
    end else begin
      res.scaled = (t > 50'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(t[31:0]);
    end
    res.prod = 64'({ph, 16'h0000}) + 64'(pl);
  end

endmodule

// ===== hdl/tdh_cordic.sv =====
module tdh_cordic #(
  parameter int CORDIC_STEPS = tdh_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] vx,
  input  logic signed [31:0] vy,
  output logic               done,
  output logic signed [15:0] w,
  output logic signed [15:0] z
);
  import tdh_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int SW    = $clog2(STEPS);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_VEC  = 4'b0010,
    C_ROT  = 4'b0100,
    C_FIN  = 4'b1000
  } cstate_t;

  cstate_t                 state;
  logic [SW-1:0]           cnt;
  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic signed [ANG_W-1:0] ang;
  logic signed [XY_W-1:0]  dx;
  logic signed [XY_W-1:0]  dy;
  logic signed [XY_W-1:0]  x_next;
  logic signed [XY_W-1:0]  y_next;
  logic signed [ANG_W-1:0] ang_next;
  logic signed [ANG_W-1:0] step_ang;
  logic                    last_step;

  // One micro-rotation, vectoring or rotating by the state.
  always_comb begin
    dx        = y >>> cnt;
    dy        = x >>> cnt;
    step_ang  = atan_q30(5'(cnt));
    last_step = (cnt == SW'(STEPS - 1));
    if ((state == C_VEC) ? (y > 0) : (ang < 0)) begin
      x_next   = (state == C_VEC) ? x + dx : x + dx;
      y_next   = y - dy;
      ang_next = (state == C_VEC) ? ang + step_ang : ang + step_ang;
    end else begin
      x_next   = x - dx;
      y_next   = y + dy;
      ang_next = ang - step_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          cnt <= '0;
          if (start) begin
            if (vx == 0 && vy == 0) begin
              // No planar motion: yaw zero, straight to rotation.
              x     <= GAIN_Q30;
              y     <= '0;
              ang   <= '0;
              state <= C_ROT;
            end else if (vx < 0) begin
              // Fold into the right half-plane.
              x     <= -XY_W'(vx);
              y     <= -XY_W'(vy);
              ang   <= (vy >= 0) ? PI_Q30 : -PI_Q30;
              state <= C_VEC;
            end else begin
              x     <= XY_W'(vx);
              y     <= XY_W'(vy);
              ang   <= '0;
              state <= C_VEC;
            end
          end
        end
        C_VEC: begin
          if (last_step) begin
            // Half the angle gives the quaternion; rotate from the gain.
            cnt   <= '0;
            x     <= GAIN_Q30;
            y     <= '0;
            ang   <= ang_next >>> 1;
            state <= C_ROT;
          end else begin
            cnt <= cnt + 1'b1;
            x   <= x_next;
            y   <= y_next;
            ang <= ang_next;
          end
        end
        C_ROT: begin
          cnt <= cnt + 1'b1;
          x   <= x_next;
          y   <= y_next;
          ang <= ang_next;
          if (last_step) begin
            state <= C_FIN;
          end
        end
        C_FIN: begin
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  assign done = (state == C_FIN);
  assign w    = to_q14(x);
  assign z    = to_q14(y);

endmodule

// ===== tb/tb_trajectory_differentiator_heading.sv =====
`timescale 1ns / 100ps

module tb_trajectory_differentiator_heading;
  import tdh_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_SAMPLES = 380;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  trajectory_differentiator_heading dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: register copies and the differentiator history.
  logic [31:0] step_rate;
  logic [31:0] speed_floor;
  longint prev_pos [3];
  longint older_pos [3];
  longint prev_vel [3];
  longint older_vel [3];
  logic signed [15:0] hold_w;
  logic signed [15:0] hold_z;
  longint seen_count;

  out_item_t pending_results [$];
  int fail_count;
  int samples_sent;
  int results_seen;
  int sequences_sent;
  int idle_cycles;

  // Directed stimulus: position and last flag.
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic last;
  } sample_row_t;

  function automatic longint shift_down(longint v, int s);
    if (v >= 0) begin
      return v >>> s;
    end
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  // Difference times the step rate, rounded, halved when central, and saturated.
  function automatic longint rate_scale(longint d, bit central);
    longint unsigned mag;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned t;
    mag = d < 0 ? longint'(-d) : longint'(d);
    hi = mag * (step_rate >> 16);
    lo = mag * (step_rate & 32'hFFFF);
    t = hi + ((lo + (central ? 64'h10000 : 64'h8000)) >> 16);
    if (central) begin
      t = t >> 1;
    end
    if (d < 0) begin
      return t > 64'h80000000 ? -64'sh80000000 : -longint'(t);
    end
    return t > 64'h7FFFFFFF ? 64'sh7FFFFFFF : longint'(t);
  endfunction

  function automatic longint arctan_step(int i);
    longint tab [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return tab[i];
  endfunction

  function automatic logic signed [15:0] round_q14(longint v);
    longint r;
    r = shift_down(v + 32768, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  // Vectoring CORDIC for the yaw, then rotation for the half-angle.
  task automatic update_heading(longint vx, longint vy);
    longint x;
    longint y;
    longint ang;
    longint dx;
    longint dy;
    x = vx;
    y = vy;
    ang = 0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        ang = y >= 0 ? 64'sd3373259426 : -64'sd3373259426;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        dx = shift_down(y, i);
        dy = shift_down(x, i);
        if (y > 0) begin
          x += dx; y -= dy; ang += arctan_step(i);
        end else begin
          x -= dx; y += dy; ang -= arctan_step(i);
        end
      end
    end
    ang = shift_down(ang, 1);
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = shift_down(y, i);
      dy = shift_down(x, i);
      if (ang >= 0) begin
        x -= dx; y += dy; ang -= arctan_step(i);
      end else begin
        x += dx; y -= dy; ang += arctan_step(i);
      end
    end
    hold_w = round_q14(x);
    hold_z = round_q14(y);
  endtask

  task automatic queue_result(longint idx, longint v [3], longint a [3], bit fin);
    out_item_t r;
    longint unsigned sq;
    longint unsigned m;
    sq = 0;
    for (int j = 0; j < 3; j++) begin
      m = v[j] < 0 ? longint'(-v[j]) : longint'(v[j]);
      sq += m * m;
    end
    if (!((v[0] == 0 && v[1] == 0 && v[2] == 0) || (sq >> 16) < speed_floor)) begin
      update_heading(v[0], v[1]);
    end
    r = '0;
    r.sample_index = idx > 65535 ? 16'hFFFF : 16'(idx);
    r.vel_x = 32'(v[0]); r.vel_y = 32'(v[1]); r.vel_z = 32'(v[2]);
    r.acc_x = 32'(a[0]); r.acc_y = 32'(a[1]); r.acc_z = 32'(a[2]);
    r.heading_w = hold_w;
    r.heading_z = hold_z;
    r.end_of_run = fin;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic clear_track();
    for (int a = 0; a < 3; a++) begin
      prev_pos[a] = 0; older_pos[a] = 0; prev_vel[a] = 0; older_vel[a] = 0;
    end
    hold_w = ONE_Q14;
    hold_z = 0;
    seen_count = 0;
  endtask

  // Work out the results that one accepted sample releases.
  task automatic predict_sample(in_item_t s);
    longint p [3];
    longint vn [3];
    longint vl [3];
    longint acc [3];
    out_item_t r;
    p[0] = s.pos_x; p[1] = s.pos_y; p[2] = s.pos_z;
    if (seen_count == 0) begin
      if (s.last_sample) begin
        r = '0;
        r.too_short = 1'b1;
        pending_results.insert(pending_results.size(), r);
        clear_track();
      end else begin
        prev_pos = p;
        seen_count = 1;
      end
      return;
    end
    for (int a = 0; a < 3; a++) begin
      vn[a] = seen_count == 1 ? rate_scale(p[a] - prev_pos[a], 0)
                              : rate_scale(p[a] - older_pos[a], 1);
    end
    if (seen_count >= 2) begin
      for (int a = 0; a < 3; a++) begin
        acc[a] = seen_count == 2 ? rate_scale(vn[a] - prev_vel[a], 0)
                                 : rate_scale(vn[a] - older_vel[a], 1);
      end
      queue_result(seen_count - 2, prev_vel, acc, 0);
    end
    if (s.last_sample) begin
      for (int a = 0; a < 3; a++) begin
        vl[a] = rate_scale(p[a] - prev_pos[a], 0);
        acc[a] = seen_count == 1 ? rate_scale(vl[a] - vn[a], 0)
                                 : rate_scale(vl[a] - prev_vel[a], 1);
      end
      queue_result(seen_count - 1, vn, acc, 0);
      for (int a = 0; a < 3; a++) begin
        acc[a] = rate_scale(vl[a] - vn[a], 0);
      end
      queue_result(seen_count, vl, acc, 1);
      clear_track();
      return;
    end
    older_pos = prev_pos;
    prev_pos = p;
    older_vel = prev_vel;
    prev_vel = vn;
    if (seen_count < 65535) seen_count++;
  endtask

  // Clock: 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern, changing on the falling edge.
  int stall_phase;
  initial stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 400 < 120) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result check at the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat, index %0d", out_data.sample_index);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.sample_index !== want.sample_index) begin
          $error("sample_index expected %0d got %0d", want.sample_index,
                 out_data.sample_index); fail_count++; end
        if (out_data.vel_x !== want.vel_x) begin
          $error("vel_x expected %0d got %0d", want.vel_x, out_data.vel_x);
          fail_count++; end
        if (out_data.vel_y !== want.vel_y) begin
          $error("vel_y expected %0d got %0d", want.vel_y, out_data.vel_y);
          fail_count++; end
        if (out_data.vel_z !== want.vel_z) begin
          $error("vel_z expected %0d got %0d", want.vel_z, out_data.vel_z);
          fail_count++; end
        if (out_data.acc_x !== want.acc_x) begin
          $error("acc_x expected %0d got %0d", want.acc_x, out_data.acc_x);
          fail_count++; end
        if (out_data.acc_y !== want.acc_y) begin
          $error("acc_y expected %0d got %0d", want.acc_y, out_data.acc_y);
          fail_count++; end
        if (out_data.acc_z !== want.acc_z) begin
          $error("acc_z expected %0d got %0d", want.acc_z, out_data.acc_z);
          fail_count++; end
        if (out_data.heading_w !== want.heading_w) begin
          $error("heading_w expected %0d got %0d", want.heading_w,
                 out_data.heading_w); fail_count++; end
        if (out_data.heading_z !== want.heading_z) begin
          $error("heading_z expected %0d got %0d", want.heading_z,
                 out_data.heading_z); fail_count++; end
        if (out_data.end_of_run !== want.end_of_run) begin
          $error("end_of_run expected %0d got %0d", want.end_of_run,
                 out_data.end_of_run); fail_count++; end
        if (out_data.too_short !== want.too_short) begin
          $error("too_short expected %0d got %0d", want.too_short,
                 out_data.too_short); fail_count++; end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("trajectory_differentiator_heading test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one sample and hold it until taken; predict on acceptance.
  task automatic send_sample(in_item_t s);
    in_data <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_sample(s);
    samples_sent++;
    if (s.last_sample) sequences_sent++;
  endtask

  task automatic release_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every expected result, then for the block to settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INV_STEP_TIME) step_rate = val; else speed_floor = val;
  endtask

  function automatic logic signed [31:0] random_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 8192))) - 4096;
      default: return $signed(32'($urandom_range(0, 32'h00400000))) - 32'sh00200000;
    endcase
  endfunction

  // Burst-and-gap sender for one random sequence; mode 0 sends random positions, others walk from a random base.
  task automatic send_random_sequence(int len, int mode);
    in_item_t s;
    logic signed [31:0] base [3];
    for (int a = 0; a < 3; a++) base[a] = random_coord(mode == 0 ? 0 : 2);
    for (int i = 0; i < len; i++) begin
      s.pos_x = mode == 0 ? random_coord(0) : base[0] + random_coord(1) * i;
      s.pos_y = mode == 0 ? random_coord(0) : base[1] + random_coord(1) * i;
      s.pos_z = mode == 0 ? random_coord(0) : base[2] + random_coord(1);
      s.last_sample = (i == len - 1);
      @(negedge clk);
      send_sample(s);
      if ($urandom_range(0, 5) == 0) begin
        release_valid();
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  endtask

  sample_row_t directed [] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b1},
    '{32'sh7FFFFFFF, -32'sh80000000, 32'sd5, 1'b0},
    '{-32'sh80000000, 32'sh7FFFFFFF, -32'sd5, 1'b1},
    '{32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{32'sd0, 32'sd0, 32'sd65536, 1'b0},
    '{32'sd0, 32'sd0, 32'sd131072, 1'b1},
    '{32'sd100, 32'sd0, 32'sd0, 1'b0},
    '{32'sd0, 32'sd100, 32'sd0, 1'b0},
    '{-32'sd100, 32'sd0, 32'sd0, 1'b0},
    '{32'sd0, -32'sd100, 32'sd0, 1'b0},
    '{32'sd100, 32'sd0, 32'sd0, 1'b1},
    '{-32'sd1, -32'sd1, -32'sd1, 1'b1}
  };

  initial begin
    in_item_t s;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_INV_STEP_TIME;
    cfg_data = '0;
    fail_count = 0;
    samples_sent = 0;
    results_seen = 0;
    sequences_sent = 0;
    idle_cycles = 0;
    step_rate = INV_STEP_TIME_RESET;
    speed_floor = MIN_SPEED_SQ_RESET;
    clear_track();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows; a lone last sample must give only the too_short beat.
    foreach (directed[i]) begin
      s.pos_x = directed[i].px;
      s.pos_y = directed[i].py;
      s.pos_z = directed[i].pz;
      s.last_sample = directed[i].last;
      @(negedge clk);
      send_sample(s);
      if (i == 0 && (pending_results.size() != 1 || !pending_results[0].too_short)) begin
        $error("too_short expected 1 got 0");
        fail_count++;
      end
    end
    drain_results();

    // Register extremes, including a zero step rate and a high speed floor.
    write_reg(REG_INV_STEP_TIME, 32'hFFFFFFFF);
    write_reg(REG_MIN_SPEED_SQ, 32'd0);
    send_random_sequence(5, 0);
    drain_results();
    write_reg(REG_INV_STEP_TIME, 32'd0);
    send_random_sequence(4, 1);
    drain_results();
    write_reg(REG_INV_STEP_TIME, 32'd1);
    write_reg(REG_MIN_SPEED_SQ, 32'hFFFFFFFF);
    send_random_sequence(4, 1);
    drain_results();

    // Random phases with different register settings.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_reg(REG_INV_STEP_TIME, 32'd65536); write_reg(REG_MIN_SPEED_SQ, 32'd0); end
        1: begin write_reg(REG_INV_STEP_TIME, $urandom()); write_reg(REG_MIN_SPEED_SQ, $urandom_range(0, 1000)); end
        2: begin write_reg(REG_INV_STEP_TIME, 32'd655360); write_reg(REG_MIN_SPEED_SQ, $urandom()); end
        default: begin write_reg(REG_INV_STEP_TIME, $urandom_range(1, 200000)); write_reg(REG_MIN_SPEED_SQ, $urandom_range(0, 100)); end
      endcase
      while (samples_sent < 40 + (phase + 1) * RANDOM_SAMPLES / 4) begin
        case ($urandom_range(0, 9))
          0: send_random_sequence(1, 0);
          1: send_random_sequence($urandom_range(2, 8), 0);
          default: send_random_sequence($urandom_range(2, 20), 1);
        endcase
      end
      drain_results();
    end

    $display("Covered %0d samples in %0d sequences, %0d result beats checked.",
             samples_sent, sequences_sent, results_seen);
    $display("Included single-sample runs, saturating extremes and held headings.");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("trajectory_differentiator_heading test passed");
    end else begin
      $display("trajectory_differentiator_heading test failed");
    end
    $finish;
  end

endmodule
